### rtl/core/lrufa_pkg.sv
// ----------------------------------------------------------------------------
// lrufa_pkg
// shared constants for the fully associative lru cache directory
// ----------------------------------------------------------------------------
package lrufa_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int ADDR_SPACE_DEF = 32;

    localparam int ADDR_W     = 5;
    localparam int SLOT_W     = 4;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

endpackage

### rtl/core/lru_fully_associative_cache_core.sv
// ----------------------------------------------------------------------------
// lru_fully_associative_cache_core
// fully associative cache directory with least-recently-used replacement
// ----------------------------------------------------------------------------
//  channel  | direction | tdata fields (lowest bit up)
//  s_axis   | in        | address[4:0], zero pad to 8 bits
//  m_axis   | out       | hit, slot[3:0], evicted_valid, evicted_address[4:0],
//           |           | zero pad to 16 bits
//
//  one request per cycle while the result is not stalled; an input register,
//  then tag compare and rank update into the result register.
//  the directory is updated in the same cycle the result is registered.
//  synchronous active-low reset clears all valid bits and both stages.
//  a stalled result holds the pipeline, the input side takes a request
//  whenever its register is empty or moves forward.
// ----------------------------------------------------------------------------
module lru_fully_associative_cache_core #(
    parameter int ENTRIES       = lrufa_pkg::ENTRIES_DEF,
    parameter int ADDRESS_SPACE = lrufa_pkg::ADDR_SPACE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // address[4:0], zero pad
    input  logic [lrufa_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // hit, slot[3:0], evicted_valid, evicted_address[4:0], zero pad
    output logic [lrufa_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import lrufa_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int RANK_W = IDX_W;
    localparam int TAB_N  = 1 << ADDR_W;
    localparam int RES_W  = 1 + SLOT_W + 1 + ADDR_W;

    // address reduction table
    logic [ADDR_W-1:0] mod_tab [TAB_N];
    for (genvar g = 0; g < TAB_N; g++) begin : g_mod
        assign mod_tab[g] = ADDR_W'(g % ADDRESS_SPACE);
    end

    logic              r_in_valid;
    logic [ADDR_W-1:0] r_in_addr;
    logic              r_out_valid;
    logic [RES_W-1:0]  r_out_data;

    logic [ENTRIES-1:0] r_valid;
    logic [ADDR_W-1:0]  r_tag  [ENTRIES];
    logic [RANK_W-1:0]  r_rank [ENTRIES];

    logic [ENTRIES-1:0] n_valid;
    logic [ADDR_W-1:0]  n_tag  [ENTRIES];
    logic [RANK_W-1:0]  n_rank [ENTRIES];
    logic [RES_W-1:0]   n_out_data;

    logic              advance;
    logic              hit_found;
    logic [IDX_W-1:0]  hit_idx;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  lru_idx;
    logic [IDX_W-1:0]  sel_idx;
    logic [RANK_W-1:0] hit_rank;
    logic [ADDR_W-1:0] ev_addr;
    logic              full;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_out_data);
    assign full            = &r_valid;

    always_comb begin
        hit_found = 1'b0;
        hit_idx   = '0;
        free_idx  = '0;
        lru_idx   = '0;
        hit_rank  = '0;
        ev_addr   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_tag[i] == r_in_addr) begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
            if (r_valid[i] && r_rank[i] == RANK_W'(ENTRIES - 1)) begin
                lru_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_valid[i] && r_tag[i] == r_in_addr) begin
                hit_rank = hit_rank | r_rank[i];
            end
            if (r_valid[i] && r_rank[i] == RANK_W'(ENTRIES - 1)) begin
                ev_addr = ev_addr | r_tag[i];
            end
        end

        if (hit_found) begin
            sel_idx = hit_idx;
        end else if (full) begin
            sel_idx = lru_idx;
        end else begin
            sel_idx = free_idx;
        end

        for (int i = 0; i < ENTRIES; i++) begin
            n_valid[i] = r_valid[i];
            n_tag[i]   = r_tag[i];
            n_rank[i]  = r_rank[i];
            if (r_valid[i] && (!hit_found || r_rank[i] < hit_rank)) begin
                n_rank[i] = r_rank[i] + 1'b1;
            end
            if (IDX_W'(i) == sel_idx) begin
                n_valid[i] = 1'b1;
                n_tag[i]   = r_in_addr;
                n_rank[i]  = '0;
            end
        end

        n_out_data = {(full && !hit_found) ? ev_addr : {ADDR_W{1'b0}},
                      full && !hit_found,
                      SLOT_W'(sel_idx),
                      hit_found};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_valid     <= n_valid;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_addr <= mod_tab[i_s_axis_tdata[ADDR_W-1:0]];
        end
        if (advance) begin
            r_out_data <= n_out_data;
            for (int i = 0; i < ENTRIES; i++) begin
                r_tag[i]  <= n_tag[i];
                r_rank[i] <= n_rank[i];
            end
        end
    end

endmodule

### bench/lru_directory_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_directory_monitor
// watches both stream channels of the lru cache directory, keeps its own copy
// of the tags, valid bits and recency ranks, and compares every result
// against the lookup it predicts for the matching request
// ----------------------------------------------------------------------------
module lru_directory_monitor (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    // address[4:0], zero pad
    input  logic [lrufa_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // hit, slot[3:0], evicted_valid, evicted_address[4:0], zero pad
    input  logic [lrufa_pkg::OUT_DATA_W-1:0] i_m_tdata,
    output int                               o_fail_count,
    output int                               o_pending
);
    import lrufa_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] evicted_address;
        logic              evicted_valid;
        logic [SLOT_W-1:0] slot;
        logic              hit;
    } t_lookup;

    localparam int LOOKUP_W = $bits(t_lookup);

    logic [ADDR_W-1:0] tag_store [ENTRIES_DEF];
    bit                tag_valid [ENTRIES_DEF];
    int                age_rank  [ENTRIES_DEF];
    int                fill_count;
    t_lookup           lookups_due [$];

    initial begin
        fill_count = 0;
        for (int i = 0; i < ENTRIES_DEF; i++) begin
            tag_store[i] = '0;
            tag_valid[i] = 1'b0;
            age_rank[i]  = 0;
        end
    end

    function automatic void age_younger(input int limit);
        for (int i = 0; i < ENTRIES_DEF; i++) begin
            if (tag_valid[i] && age_rank[i] < limit) begin
                age_rank[i]++;
            end
        end
    endfunction

    function automatic t_lookup lru_lookup(input logic [ADDR_W-1:0] raw_addr);
        t_lookup           res;
        logic [ADDR_W-1:0] addr;
        int                way;
        int                oldest;
        bit                found;
        res    = '0;
        addr   = ADDR_W'(int'(raw_addr) % ADDR_SPACE_DEF);
        way    = 0;
        oldest = -1;
        found  = 1'b0;
        for (int i = 0; i < ENTRIES_DEF; i++) begin
            if (!found && tag_valid[i] && tag_store[i] == addr) begin
                found = 1'b1;
                way   = i;
            end
        end
        if (found) begin
            res.hit = 1'b1;
            age_younger(age_rank[way]);
        end else begin
            if (fill_count < ENTRIES_DEF) begin
                for (int i = ENTRIES_DEF - 1; i >= 0; i--) begin
                    if (!tag_valid[i]) begin
                        way = i;
                    end
                end
                fill_count++;
            end else begin
                // oldest valid slot, lowest index on a rank tie
                for (int i = 0; i < ENTRIES_DEF; i++) begin
                    if (tag_valid[i] && age_rank[i] > oldest) begin
                        oldest = age_rank[i];
                        way    = i;
                    end
                end
                res.evicted_valid   = 1'b1;
                res.evicted_address = tag_store[way];
            end
            age_younger(32'h7fff_ffff);
            tag_valid[way] = 1'b1;
            tag_store[way] = addr;
        end
        age_rank[way] = 0;
        res.slot      = SLOT_W'(way);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_lookup got;
        t_lookup want;
        t_lookup next_due;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_lookup'(i_m_tdata[LOOKUP_W-1:0]);
                if (lookups_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = lookups_due.pop_front();
                    if (got.hit !== want.hit) begin
                        $display("%0t: hit mismatch, expected %0d actual %0d",
                                 $time, want.hit, got.hit);
                    end
                    if (got.slot !== want.slot) begin
                        $display("%0t: slot mismatch, expected %0d actual %0d",
                                 $time, want.slot, got.slot);
                    end
                    if (got.evicted_valid !== want.evicted_valid) begin
                        $display("%0t: evicted_valid mismatch, expected %0d actual %0d",
                                 $time, want.evicted_valid, got.evicted_valid);
                    end
                    if (got.evicted_address !== want.evicted_address) begin
                        $display("%0t: evicted_address mismatch, expected %0d actual %0d",
                                 $time, want.evicted_address, got.evicted_address);
                    end
                    if (got !== want) begin
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                next_due = lru_lookup(i_s_tdata[ADDR_W-1:0]);
                lookups_due.insert(lookups_due.size(), next_due);
            end
        end
        o_pending <= lookups_due.size();
    end

endmodule

### bench/lru_fully_associative_cache_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_fully_associative_cache_core_test
// drives address requests into the lru cache directory with random gaps and
// output stalls, including a long output hold-off, and reports the verdict
// from the monitor's failure count
// ----------------------------------------------------------------------------
module lru_fully_associative_cache_core_test;
    import lrufa_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_STALL  = 80;
    localparam int PHASE_ITEMS = 300;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  s_tvalid   = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata    = '0;
    logic                  m_tvalid;
    logic                  m_tready   = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int                    fail_count;
    int                    pending;
    int                    send_idle_pct   = 0;
    int                    recv_idle_pct   = 0;
    int                    stall_req_count = 0;
    int                    cycle_count     = 0;
    logic [ADDR_W-1:0]     recent [8]      = '{default: '0};

    lru_fully_associative_cache_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    lru_directory_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[lru_fully_associative_cache_core] ERROR");
            $finish;
        end
    end

    initial begin : receiver
        int stall_left;
        int stall_seen;
        stall_left = 0;
        stall_seen = 0;
        forever begin
            @(posedge i_clk);
            if (stall_seen != stall_req_count) begin
                stall_seen = stall_req_count;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_addr(input logic [ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(addr);
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        logic [ADDR_W-1:0] addr;
        for (int k = 0; k < count; k++) begin
            // reuse recent addresses now and then for runs of hits
            if ($urandom_range(0, 2) == 0) begin
                addr = recent[$urandom_range(0, 7)];
            end else begin
                addr = ADDR_W'($urandom_range(0, 31));
            end
            recent[k % 8] = addr;
            send_addr(addr);
        end
    endtask

    initial begin : stimulus
        logic [ADDR_W-1:0] directed [25];
        directed = '{5'd0, 5'd31, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7,
                     5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14,
                     5'd0, 5'd15, 5'd31, 5'd15, 5'd10,
                     5'd16, 5'd17, 5'd18, 5'd19};
        repeat (4) @(posedge i_clk);
        i_rst_n       <= 1'b1;
        send_idle_pct <= 8;
        recv_idle_pct <= 87;
        @(posedge i_clk);

        // fill, hit on oldest, then evictions mixed with hits
        foreach (directed[k]) begin
            send_addr(directed[k]);
        end
        run_random(PHASE_ITEMS);
        drain();

        send_idle_pct <= 87;
        recv_idle_pct <= 8;
        @(posedge i_clk);
        run_random(PHASE_ITEMS);
        drain();

        send_idle_pct   <= 0;
        recv_idle_pct   <= 0;
        stall_req_count <= stall_req_count + 1;
        @(posedge i_clk);
        run_random(PHASE_ITEMS);
        drain();

        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[lru_fully_associative_cache_core] OK");
        end else begin
            $display("[lru_fully_associative_cache_core] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/lrufa_pkg.sv
rtl/core/lru_fully_associative_cache_core.sv
bench/lru_directory_monitor.sv
bench/lru_fully_associative_cache_core_test.sv
